>>> src/dde_pkg.sv
// Shared types and constants for the deadlock detection engine.
// Holds the request and response word layouts, opcodes and register map.
// Depends on nothing; every other file of the block imports it.
package dde_pkg;

   // Defaults for the sizing parameters of the top level.
   localparam int DEF_MAX_PROCS = 16;
   localparam int DEF_MAX_TYPES = 8;

   // Fixed field widths of the request and response words.
   localparam int AMOUNT_W = 8;
   localparam int MASK_W   = 16;

   // Register port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_PROCESS_COUNT = 1'b0;
   localparam logic [0:0] REG_TYPE_COUNT    = 1'b1;
   localparam logic [4:0] PROCESS_COUNT_RST = 5'd16;
   localparam logic [3:0] TYPE_COUNT_RST    = 4'd8;

   // Request opcodes.
   typedef enum logic [1:0] {
      OP_TOTAL   = 2'd0,
      OP_ALLOC   = 2'd1,
      OP_REQUEST = 2'd2,
      OP_RUN     = 2'd3
   } op_type;

   // Operation of the shared adder.
   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   // One request word.
   typedef struct packed {
      op_type              op;
      logic [3:0]          proc_index;
      logic [2:0]          type_index;
      logic [AMOUNT_W-1:0] amount;
   } req_word_type;

   // One response word.
   typedef struct packed {
      logic [MASK_W-1:0] deadlocked_mask;
      logic              any_deadlock;
   } rsp_word_type;

   // Write strobes into the three stores.
   typedef struct packed {
      logic total;
      logic alloc;
      logic request;
   } store_we_type;

endpackage

>>> src/dde_store.sv
// Storage for resource totals, the allocation matrix and the request matrix.
// One write port and one registered read port per store; uses dde_pkg.
module dde_store #(
   parameter int MAX_PROCS = dde_pkg::DEF_MAX_PROCS,
   parameter int MAX_TYPES = dde_pkg::DEF_MAX_TYPES,
   parameter int T_W       = 3,
   parameter int ADDR_W    = 7
) (
   input  logic                          clock,
   input  dde_pkg::store_we_type         wr_en,
   input  logic [T_W-1:0]                wr_type,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic [dde_pkg::AMOUNT_W-1:0]  wr_data,
   input  logic [T_W-1:0]                rd_type,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic [dde_pkg::AMOUNT_W-1:0]  total_rd,
   output logic [dde_pkg::AMOUNT_W-1:0]  alloc_rd,
   output logic [dde_pkg::AMOUNT_W-1:0]  request_rd
);
   import dde_pkg::*;

   localparam int DEPTH = MAX_PROCS * MAX_TYPES;

   logic [AMOUNT_W-1:0] total_mem   [MAX_TYPES];
   logic [AMOUNT_W-1:0] alloc_mem   [DEPTH];
   logic [AMOUNT_W-1:0] request_mem [DEPTH];
   logic [AMOUNT_W-1:0] total_rd_ff;
   logic [AMOUNT_W-1:0] alloc_rd_ff;
   logic [AMOUNT_W-1:0] request_rd_ff;

   // Writes from load words and registered reads for the sequencer.
   always_ff @(posedge clock) begin
      if (wr_en.total) begin
         total_mem[wr_type] <= wr_data;
      end
      if (wr_en.alloc) begin
         alloc_mem[wr_addr] <= wr_data;
      end
      if (wr_en.request) begin
         request_mem[wr_addr] <= wr_data;
      end
      total_rd_ff   <= total_mem[rd_type];
      alloc_rd_ff   <= alloc_mem[rd_addr];
      request_rd_ff <= request_mem[rd_addr];
   end

   assign total_rd   = total_rd_ff;
   assign alloc_rd   = alloc_rd_ff;
   assign request_rd = request_rd_ff;

endmodule

>>> src/dde_alu.sv
// Shared signed adder of the detection sequencer.
// Builds availability, tests requests against it and returns allocations.
module dde_alu #(
   parameter int WORK_W = 14
) (
   input  dde_pkg::alu_op_type  op,
   input  logic [WORK_W-1:0]    a,
   input  logic [WORK_W-1:0]    b,
   output logic [WORK_W-1:0]    y
);
   import dde_pkg::*;

   // Two's complement add or subtract; the sign bit serves as the compare.
   always_comb begin
      case (op)
         ALU_SUB: y = a - b;
         default: y = a + b;
      endcase
   end

endmodule

>>> src/deadlock_detection_engine_unit.sv
// Top level of the deadlock detection engine.
// Depends on dde_pkg, dde_store and dde_alu.
//
// Usage: request words arrive on req_valid/req_ready with req_word. A load
// word (op total, allocation or request) writes one store entry when it is
// taken; it produces no response. A run word starts detection and
// yields one response word on rsp_valid/rsp_ready: a mask of the deadlocked
// processes in use and a flag that any exists.
// Run sequence: every step reads the stores through their registered read
// port and then uses the one shared adder. A sweep that builds availability
// over all processes and types in use is followed by detection passes, at
// most P+1 of them with P processes in use, until a pass marks no new
// process. req_ready is low while a run is in progress.
// The response sits in an output register; load words keep being accepted
// while it waits. A run that finishes while the receiver stalls holds until
// the previous response is taken.
// Reset (synchronous, active high) returns to idle, drops rsp_valid and sets
// process_count to 16 and type_count to 8. Store contents are undefined until
// written; no clearing pass is made.
module deadlock_detection_engine_unit #(
   parameter int MAX_PROCS = dde_pkg::DEF_MAX_PROCS,
   parameter int MAX_TYPES = dde_pkg::DEF_MAX_TYPES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  dde_pkg::req_word_type           req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output dde_pkg::rsp_word_type           rsp_word,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [dde_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [dde_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [dde_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import dde_pkg::*;

   localparam int P_W    = $clog2(MAX_PROCS);
   localparam int T_W    = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
   localparam int ADDR_W = $clog2(MAX_PROCS * MAX_TYPES);
   localparam int WORK_W = $clog2((MAX_PROCS + 1) * 256) + 1;
   localparam int MASK_N = (MAX_PROCS < MASK_W) ? MAX_PROCS : MASK_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_AV_RD,
      S_AV_OP,
      S_CK_RD,
      S_CK_OP,
      S_AD_RD,
      S_AD_OP,
      S_DONE
   } state_type;

   // Registers.
   state_type          state_ff, state_in;
   logic [P_W-1:0]     p_ff, p_in;
   logic [T_W-1:0]     t_ff, t_in;
   logic [P_W-1:0]     np_last_ff, np_last_in;
   logic [T_W-1:0]     nt_last_ff, nt_last_in;
   logic [WORK_W-1:0]  acc_ff, acc_in;
   logic [MAX_PROCS-1:0] marks_ff, marks_in;
   logic               progress_ff, progress_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;
   logic [WORK_W-1:0]  work_ff [MAX_TYPES];
   logic [4:0]         process_count_ff;
   logic [3:0]         type_count_ff;

   // Combinational signals.
   logic               req_accept;
   logic               type_ok;
   logic               proc_ok;
   store_we_type       store_we;
   logic [T_W-1:0]     wr_type;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic [AMOUNT_W-1:0] total_rd;
   logic [AMOUNT_W-1:0] alloc_rd;
   logic [AMOUNT_W-1:0] request_rd;
   logic [P_W-1:0]     np_last_c;
   logic [T_W-1:0]     nt_last_c;
   logic [MAX_PROCS-1:0] in_use_new;
   logic [MAX_PROCS-1:0] in_use_run;
   logic [MAX_PROCS-1:0] dead;
   rsp_word_type       result_c;
   alu_op_type         alu_op;
   logic [WORK_W-1:0]  alu_a;
   logic [WORK_W-1:0]  alu_b;
   logic [WORK_W-1:0]  alu_y;
   logic [WORK_W-1:0]  work_rd;
   logic               work_we;
   logic               advance;
   logic               csr_write;

   // Register port: always ready, writes on the access phase.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         process_count_ff <= PROCESS_COUNT_RST;
         type_count_ff    <= TYPE_COUNT_RST;
      end else if (csr_write) begin
         case (csr_paddr[2])
            REG_PROCESS_COUNT: process_count_ff <= csr_pwdata[4:0];
            default:           type_count_ff    <= csr_pwdata[3:0];
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_PROCESS_COUNT: csr_prdata = CSR_DATA_W'(process_count_ff);
         default:           csr_prdata = CSR_DATA_W'(type_count_ff);
      endcase
   end

   // Counts in use: zero means one, larger than the maximum saturates.
   always_comb begin
      if (process_count_ff == '0) begin
         np_last_c = '0;
      end else if (int'(process_count_ff) > MAX_PROCS) begin
         np_last_c = P_W'(MAX_PROCS - 1);
      end else begin
         np_last_c = P_W'(int'(process_count_ff) - 1);
      end
      if (type_count_ff == '0) begin
         nt_last_c = '0;
      end else if (int'(type_count_ff) > MAX_TYPES) begin
         nt_last_c = T_W'(MAX_TYPES - 1);
      end else begin
         nt_last_c = T_W'(int'(type_count_ff) - 1);
      end
   end

   // Processes in use, for a new run and for the run in progress.
   always_comb begin
      for (int i = 0; i < MAX_PROCS; i++) begin
         in_use_new[i] = (i <= int'(np_last_c));
         in_use_run[i] = (i <= int'(np_last_ff));
      end
   end

   // Response word from the final marks.
   assign dead = ~marks_ff & in_use_run;

   always_comb begin
      result_c = '0;
      for (int i = 0; i < MASK_N; i++) begin
         result_c.deadlocked_mask[i] = dead[i];
      end
      result_c.any_deadlock = |dead;
   end

   // Load words write the stores; out-of-range indexes are dropped.
   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid & req_ready;
   assign type_ok    = int'(req_word.type_index) < MAX_TYPES;
   assign proc_ok    = int'(req_word.proc_index) < MAX_PROCS;

   always_comb begin
      store_we.total   = req_accept && (req_word.op == OP_TOTAL) && type_ok;
      store_we.alloc   = req_accept && (req_word.op == OP_ALLOC) && type_ok && proc_ok;
      store_we.request = req_accept && (req_word.op == OP_REQUEST) && type_ok && proc_ok;
   end

   assign wr_type = T_W'(req_word.type_index);
   assign wr_addr = ADDR_W'(int'(req_word.proc_index) * MAX_TYPES
                            + int'(req_word.type_index));
   assign rd_addr = ADDR_W'(int'(p_ff) * MAX_TYPES + int'(t_ff));

   dde_store #(
      .MAX_PROCS (MAX_PROCS),
      .MAX_TYPES (MAX_TYPES),
      .T_W       (T_W),
      .ADDR_W    (ADDR_W)
   ) u_store (
      .clock      (clock),
      .wr_en      (store_we),
      .wr_type    (wr_type),
      .wr_addr    (wr_addr),
      .wr_data    (req_word.amount),
      .rd_type    (t_ff),
      .rd_addr    (rd_addr),
      .total_rd   (total_rd),
      .alloc_rd   (alloc_rd),
      .request_rd (request_rd)
   );

   // Operand selection for the shared adder.
   assign work_rd = work_ff[t_ff];

   always_comb begin
      case (state_ff)
         S_AV_OP: begin
            alu_op = ALU_SUB;
            alu_a  = (p_ff == '0) ? WORK_W'(total_rd) : acc_ff;
            alu_b  = WORK_W'(alloc_rd);
         end
         S_CK_OP: begin
            alu_op = ALU_SUB;
            alu_a  = work_rd;
            alu_b  = WORK_W'(request_rd);
         end
         default: begin
            alu_op = ALU_ADD;
            alu_a  = work_rd;
            alu_b  = WORK_W'(alloc_rd);
         end
      endcase
   end

   dde_alu #(
      .WORK_W (WORK_W)
   ) u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .y  (alu_y)
   );

   // Sequencer: availability sweep, then passes until one marks nothing.
   always_comb begin
      state_in     = state_ff;
      p_in         = p_ff;
      t_in         = t_ff;
      np_last_in   = np_last_ff;
      nt_last_in   = nt_last_ff;
      acc_in       = acc_ff;
      marks_in     = marks_ff;
      progress_in  = progress_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      work_we      = 1'b0;
      advance      = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_word.op == OP_RUN)) begin
               np_last_in = np_last_c;
               nt_last_in = nt_last_c;
               marks_in   = in_use_new;
               p_in       = '0;
               t_in       = '0;
               state_in   = S_AV_RD;
            end
         end
         S_AV_RD: begin
            state_in = S_AV_OP;
         end
         S_AV_OP: begin
            // A process holding anything is not idle.
            acc_in = alu_y;
            if (alloc_rd != '0) begin
               marks_in[p_ff] = 1'b0;
            end
            if (p_ff == np_last_ff) begin
               work_we = 1'b1;
               p_in    = '0;
               if (t_ff == nt_last_ff) begin
                  t_in        = '0;
                  progress_in = 1'b0;
                  state_in    = S_CK_RD;
               end else begin
                  t_in     = t_ff + 1'b1;
                  state_in = S_AV_RD;
               end
            end else begin
               p_in     = p_ff + 1'b1;
               state_in = S_AV_RD;
            end
         end
         S_CK_RD: begin
            if (marks_ff[p_ff]) begin
               advance = 1'b1;
            end else begin
               state_in = S_CK_OP;
            end
         end
         S_CK_OP: begin
            // Negative difference means the request exceeds the work value.
            if (alu_y[WORK_W-1]) begin
               t_in    = '0;
               advance = 1'b1;
            end else if (t_ff == nt_last_ff) begin
               marks_in[p_ff] = 1'b1;
               progress_in    = 1'b1;
               t_in           = '0;
               state_in       = S_AD_RD;
            end else begin
               t_in     = t_ff + 1'b1;
               state_in = S_CK_RD;
            end
         end
         S_AD_RD: begin
            state_in = S_AD_OP;
         end
         S_AD_OP: begin
            // Return the finished process's allocation to the work vector.
            work_we = 1'b1;
            if (t_ff == nt_last_ff) begin
               t_in    = '0;
               advance = 1'b1;
            end else begin
               t_in     = t_ff + 1'b1;
               state_in = S_AD_RD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = result_c;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Move to the next process, or end the pass.
      if (advance) begin
         if (p_ff == np_last_ff) begin
            p_in = '0;
            if (progress_ff) begin
               progress_in = 1'b0;
               state_in    = S_CK_RD;
            end else begin
               state_in = S_DONE;
            end
         end else begin
            p_in     = p_ff + 1'b1;
            state_in = S_CK_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         p_ff         <= '0;
         t_ff         <= '0;
         np_last_ff   <= '0;
         nt_last_ff   <= '0;
         marks_ff     <= '0;
         progress_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         work_ff      <= '{default: '0};
      end else begin
         state_ff     <= state_in;
         p_ff         <= p_in;
         t_ff         <= t_in;
         np_last_ff   <= np_last_in;
         nt_last_ff   <= nt_last_in;
         marks_ff     <= marks_in;
         progress_ff  <= progress_in;
         rsp_valid_ff <= rsp_valid_in;
         if (work_we) begin
            work_ff[t_ff] <= alu_y;
         end
      end
      acc_ff      <= acc_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

>>> test/tb_deadlock_detection_engine_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for deadlock_detection_engine_unit.
// Loads resource stores, runs detection and checks each verdict against its own predictor.
// Depends on dde_pkg and the RTL of the block only.
module tb_deadlock_detection_engine_unit;
   import dde_pkg::*;

   localparam int NP = DEF_MAX_PROCS;
   localparam int NT = DEF_MAX_TYPES;
   localparam int ITEM_TARGET = 1600;
   localparam int LONG_HOLD = 1500;
   localparam int SETTLE_CYCLES = 16;
   localparam logic [CSR_ADDR_W-1:0] ADDR_PROCS = {REG_PROCESS_COUNT, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_TYPES = {REG_TYPE_COUNT, 2'b00};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // Words waiting to be sent and verdicts waiting to come back.
   req_word_type pending_words[$];
   rsp_word_type pending_verdicts[$];
   int fail_count = 0;
   int queued_items = 0;

   // Predictor state: stores, work vector, marks and the count registers.
   logic [AMOUNT_W-1:0] totals_m [NT];
   logic [AMOUNT_W-1:0] alloc_m [NP][NT];
   logic [AMOUNT_W-1:0] request_m [NP][NT];
   logic signed [13:0] work_m [NT];
   logic [NP-1:0] marks_m = '0;
   logic [4:0] cfg_procs = PROCESS_COUNT_RST;
   logic [3:0] cfg_types = TYPE_COUNT_RST;

   // Stimulus bookkeeping: which entries hold a value, and the counts in use.
   bit total_set [NT];
   bit alloc_set [NP][NT];
   bit request_set [NP][NT];
   int gen_procs = 16;
   int gen_types = 8;

   // Handshake pacing on both sides.
   int src_gap = 0;
   int src_calm = 0;
   int sink_gap = 0;
   int sink_calm = 0;
   int sink_hold = 0;
   logic hold_go = 1'b0;

   deadlock_detection_engine_unit #(
      .MAX_PROCS(NP),
      .MAX_TYPES(NT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word(rsp_word),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // A zero count acts as one; a count above the maximum saturates.
   function automatic int clamp_count(int v, int top);
      if (v == 0) return 1;
      return (v > top) ? top : v;
   endfunction

   // Idle cycles before the next word, with occasional stretches of none at all.
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 8);
   endfunction

   // Runs detection on the predictor state and returns the verdict.
   function automatic rsp_word_type detect_deadlock();
      int np;
      int nt;
      logic progress;
      logic fits;
      logic idle;
      rsp_word_type v;
      np = clamp_count(cfg_procs, NP);
      nt = clamp_count(cfg_types, NT);
      // Availability is the total minus every allocation in use.
      for (int t = 0; t < nt; t++) begin
         work_m[t] = $signed({6'b0, totals_m[t]});
         for (int p = 0; p < np; p++)
            work_m[t] = work_m[t] - $signed({6'b0, alloc_m[p][t]});
      end
      // Processes that hold nothing start out finished.
      for (int p = 0; p < NP; p++) begin
         idle = 1'b1;
         if (p < np)
            for (int t = 0; t < nt; t++)
               if (alloc_m[p][t] != 0) idle = 1'b0;
         marks_m[p] = (p < np) && idle;
      end
      // Keep passing until a pass finishes nobody new.
      do begin
         progress = 1'b0;
         for (int p = 0; p < np; p++) begin
            if (!marks_m[p]) begin
               fits = 1'b1;
               for (int t = 0; t < nt; t++)
                  if ($signed({6'b0, request_m[p][t]}) > work_m[t]) fits = 1'b0;
               if (fits) begin
                  marks_m[p] = 1'b1;
                  for (int t = 0; t < nt; t++)
                     work_m[t] = work_m[t] + $signed({6'b0, alloc_m[p][t]});
                  progress = 1'b1;
               end
            end
         end
      end while (progress);
      v = '0;
      for (int p = 0; p < np; p++)
         if (!marks_m[p]) begin
            v.any_deadlock = 1'b1;
            v.deadlocked_mask[p] = 1'b1;
         end
      return v;
   endfunction

   // Applies one accepted word to the predictor.
   function automatic void apply_request(req_word_type w);
      case (w.op)
         OP_TOTAL: totals_m[w.type_index] = w.amount;
         OP_ALLOC: alloc_m[w.proc_index][w.type_index] = w.amount;
         OP_REQUEST: request_m[w.proc_index][w.type_index] = w.amount;
         OP_RUN: pending_verdicts.push_back(detect_deadlock());
         default: ;
      endcase
   endfunction

   // Sender: presents queued words, drawing an idle gap after each one.
   always @(posedge clock) begin
      logic held;
      int gap;
      if (reset) begin
         req_valid <= 1'b0;
         req_word <= '0;
         src_gap <= 0;
      end else begin
         held = req_valid;
         gap = src_gap;
         if (req_valid && req_ready) begin
            apply_request(req_word);
            held = 1'b0;
            gap = draw_gap(src_calm);
         end
         if (!held) begin
            if (gap == 0 && pending_words.size() > 0) begin
               req_word <= pending_words.pop_front();
               held = 1'b1;
            end else if (gap > 0) begin
               gap--;
            end
         end
         req_valid <= held;
         src_gap <= gap;
      end
   end

   // Receiver: stalls a random time after each word and holds off on request.
   always @(posedge clock) begin
      int gap;
      int hold;
      if (reset) begin
         rsp_ready <= 1'b0;
         sink_gap <= 0;
         sink_hold <= 0;
      end else begin
         gap = sink_gap;
         hold = sink_hold;
         if (rsp_valid && rsp_ready) gap = draw_gap(sink_calm);
         else if (gap > 0) gap--;
         if (hold_go) hold = LONG_HOLD;
         else if (hold > 0) hold--;
         sink_gap <= gap;
         sink_hold <= hold;
         rsp_ready <= (gap == 0) && (hold == 0);
      end
   end

   // Checks every accepted verdict against the oldest one predicted.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            $error("unexpected response word %h with no run pending", rsp_word);
            fail_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_word.deadlocked_mask !== want.deadlocked_mask) begin
               $error("deadlocked_mask: expected %h, actual %h",
                      want.deadlocked_mask, rsp_word.deadlocked_mask);
               fail_count++;
            end
            if (rsp_word.any_deadlock !== want.any_deadlock) begin
               $error("any_deadlock: expected %b, actual %b",
                      want.any_deadlock, rsp_word.any_deadlock);
               fail_count++;
            end
         end
      end
   end

   // One register transfer: setup cycle, then access until pready.
   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic verify_count_regs();
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b0, ADDR_PROCS, '0, rd);
      if (rd[4:0] !== cfg_procs) begin
         $error("process_count: expected %0d, actual %0d", cfg_procs, rd[4:0]);
         fail_count++;
      end
      csr_access(1'b0, ADDR_TYPES, '0, rd);
      if (rd[3:0] !== cfg_types) begin
         $error("type_count: expected %0d, actual %0d", cfg_types, rd[3:0]);
         fail_count++;
      end
   endtask

   // Writes both count registers while the block is idle, then reads them back.
   task automatic set_counts(int procs, int types);
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b1, ADDR_PROCS, CSR_DATA_W'(procs), rd);
      cfg_procs = 5'(procs);
      csr_access(1'b1, ADDR_TYPES, CSR_DATA_W'(types), rd);
      cfg_types = 4'(types);
      verify_count_regs();
      gen_procs = clamp_count(procs, NP);
      gen_types = clamp_count(types, NT);
   endtask

   task automatic queue_word(op_type op, int p, int t, int amount);
      req_word_type w;
      w.op = op;
      w.proc_index = 4'(p);
      w.type_index = 3'(t);
      w.amount = AMOUNT_W'(amount);
      case (op)
         OP_TOTAL: total_set[t] = 1'b1;
         OP_ALLOC: alloc_set[p][t] = 1'b1;
         OP_REQUEST: request_set[p][t] = 1'b1;
         default: ;
      endcase
      pending_words.push_back(w);
      queued_items++;
   endtask

   // A run word, preceded by loads of any entry in use that was never written.
   task automatic queue_run();
      for (int t = 0; t < gen_types; t++)
         if (!total_set[t]) queue_word(OP_TOTAL, $urandom_range(0, 15), t, $urandom_range(0, 20));
      for (int p = 0; p < gen_procs; p++)
         for (int t = 0; t < gen_types; t++) begin
            if (!alloc_set[p][t]) queue_word(OP_ALLOC, p, t, $urandom_range(0, 3));
            if (!request_set[p][t]) queue_word(OP_REQUEST, p, t, $urandom_range(0, 3));
         end
      queue_word(OP_RUN, $urandom_range(0, 15), $urandom_range(0, 7), $urandom_range(0, 255));
   endtask

   // A full, plausible system: small allocations, totals near their sum, small requests.
   task automatic queue_scenario();
      int held [NP][NT];
      int sum;
      for (int p = 0; p < gen_procs; p++)
         for (int t = 0; t < gen_types; t++) begin
            held[p][t] = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 3));
            queue_word(OP_ALLOC, p, t, held[p][t]);
         end
      for (int t = 0; t < gen_types; t++) begin
         sum = int'($urandom_range(0, 4));
         for (int p = 0; p < gen_procs; p++) sum += held[p][t];
         // Now and then the totals fall short of what is allocated.
         if ($urandom_range(0, 5) == 0) sum -= int'($urandom_range(1, 3));
         if (sum < 0) sum = 0;
         queue_word(OP_TOTAL, $urandom_range(0, 15), t, sum);
      end
      for (int p = 0; p < gen_procs; p++)
         for (int t = 0; t < gen_types; t++)
            queue_word(OP_REQUEST, p, t,
                       ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(0, 4)));
      queue_run();
   endtask

   // A few updates, mostly small ones in use and sometimes noise anywhere, then a run.
   task automatic queue_tweak();
      int n;
      n = $urandom_range(0, 3);
      repeat (n) begin
         if ($urandom_range(0, 5) == 0)
            queue_word(op_type'(2'($urandom_range(0, 2))), $urandom_range(0, 15),
                       $urandom_range(0, 7), $urandom_range(0, 255));
         else
            queue_word(op_type'(2'($urandom_range(0, 2))), $urandom_range(0, gen_procs - 1),
                       $urandom_range(0, gen_types - 1), $urandom_range(0, 4));
      end
      queue_run();
   endtask

   // Waits until every word is sent and every verdict is back, then lets the block settle.
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_words.size() != 0 || req_valid || pending_verdicts.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int phase;
      int large_seen;
      int tweaks;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      verify_count_regs();

      // Directed words on two processes and two types.
      set_counts(2, 2);
      queue_word(OP_TOTAL, 15, 0, 255);
      queue_word(OP_TOTAL, 0, 1, 3);
      queue_word(OP_ALLOC, 0, 0, 0);
      queue_word(OP_ALLOC, 0, 1, 0);
      queue_word(OP_ALLOC, 1, 0, 2);
      queue_word(OP_ALLOC, 1, 1, 1);
      // A process that holds nothing is finished whatever it asks for.
      queue_word(OP_REQUEST, 0, 0, 255);
      queue_word(OP_REQUEST, 0, 1, 0);
      queue_word(OP_REQUEST, 1, 0, 1);
      queue_word(OP_REQUEST, 1, 1, 1);
      queue_run();
      // Availability of type one goes negative, so process one is stuck.
      queue_word(OP_TOTAL, 7, 1, 0);
      queue_run();
      // Even a zero request does not fit a negative work entry.
      queue_word(OP_REQUEST, 1, 1, 0);
      queue_run();
      // Entries beyond the counts in use are stored but never read.
      queue_word(OP_ALLOC, 15, 7, 255);
      queue_word(OP_REQUEST, 15, 7, 255);
      queue_run();
      wait_drained();
      // Zero counts behave as one process and one type.
      set_counts(0, 0);
      queue_run();
      wait_drained();

      // Random phases, mostly small; a couple at or beyond the maximum counts.
      phase = 0;
      large_seen = 0;
      while (queued_items < ITEM_TARGET) begin
         if (phase % 10 == 5) begin
            if (large_seen == 0) set_counts(31, 15);
            else set_counts($urandom_range(16, 31), $urandom_range(8, 15));
            large_seen++;
            tweaks = 3;
            queue_scenario();
         end else if (phase == 2) begin
            // The receiver holds off while words keep coming, so the block fills up.
            set_counts(3, 2);
            queue_scenario();
            hold_go <= 1'b1;
            @(posedge clock);
            hold_go <= 1'b0;
            tweaks = 16;
         end else begin
            set_counts($urandom_range(0, 8), $urandom_range(0, 4));
            tweaks = $urandom_range(3, 8);
            queue_scenario();
         end
         repeat (tweaks) queue_tweak();
         wait_drained();
         phase++;
      end

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(20_000_000);
      $display("Some tests failed");
      $finish;
   end

endmodule

>>> filelist.f
src/dde_pkg.sv
src/dde_store.sv
src/dde_alu.sv
src/deadlock_detection_engine_unit.sv
test/tb_deadlock_detection_engine_unit.sv
